// ===== src/gbn_pkg.sv =====
// Shared types and constants of the go-back-N sender.
package gbn_pkg;

	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	localparam logic [1:0] REG_WIN_LEN      = 2'd0;
	localparam logic [1:0] REG_FRAME_TOTAL  = 2'd1;
	localparam logic [1:0] REG_IMPAIR_FRAME = 2'd2;
	localparam logic [1:0] REG_IMPAIR_KIND  = 2'd3;

	localparam logic [1:0] IMP_ACK_LOSS = 2'd1;
	localparam logic [1:0] IMP_CORRUPT  = 2'd2;

	typedef enum logic [1:0] {
		ACT_START   = 2'd0,
		ACT_ACK     = 2'd1,
		ACT_TIMEOUT = 2'd2
	} act_t;

	typedef enum logic [2:0] {
		KIND_TRANSMIT   = 3'd0,
		KIND_DELIVERED  = 3'd1,
		KIND_UNEXPECTED = 3'd2,
		KIND_TIMEOUT    = 3'd3,
		KIND_IDLE       = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		CMD_START   = 2'd0,
		CMD_ACK     = 2'd1,
		CMD_TIMEOUT = 2'd2,
		CMD_NONE    = 2'd3
	} cmd_op_t;

	typedef struct packed {
		act_t       action;
		logic [4:0] ack_seq;
	} req_t;

	typedef struct packed {
		kind_t       kind;
		logic [4:0]  wire_seq;
		logic [15:0] frame_index;
		logic [15:0] attempt;
		logic        ack_loss_mark;
		logic        corrupted;
		logic [31:0] total_sent;
		logic        last;
	} rsp_t;

	typedef struct packed {
		cmd_op_t    op;
		logic [4:0] ack_seq;
	} cmd_t;

	typedef struct packed {
		logic [4:0]  win_len;
		logic [15:0] frame_total;
		logic [16:0] impair_frame;
		logic [1:0]  impair_kind;
	} cfg_t;

	typedef struct packed {
		logic [15:0] frame;
		logic [15:0] attempts;
	} ring_entry_t;

endpackage

// ===== src/go_back_n_sender.sv =====
// Top level of the go-back-N sender.
//
// Channel   Direction  Handshake                Payload
// request   in         push / full              req (action, ack_seq)
// result    out        pop / empty              rsp (kind ... last)
// config    in         psel, penable, pready    paddr, pwdata, prdata
//
// A status result (idle, finished or unknown action) passes through the done state.
// A start goes to the fill state, and on to the done state as well when it sends nothing.
// An ACK or timeout reads the ring head for the event state; a delivery then goes to the fill
// state, and to the done state too when it ends the session; a miss resends the full window.
// A request passes through the command queue and the sequencer state before its first result.
// A full result queue stalls the sequencer without losing state; two commands queue ahead.
module go_back_n_sender
	import gbn_pkg::*;
#(
	parameter int MAX_WINDOW = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  req_t              req,
	output logic              empty,
	input  logic              pop,
	output rsp_t              rsp,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	cfg_t                    cfg;
	logic                    cmd_valid;
	cmd_t                    cmd;
	logic                    cmd_pop;
	logic                    out_full;
	logic                    out_push;
	rsp_t                    out_data;
	logic [$bits(rsp_t)-1:0] rsp_raw;

	gbn_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	gbn_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.req       (req),
		.full      (full),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	gbn_back #(
		.MAX_WINDOW (MAX_WINDOW)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.out_full  (out_full),
		.out_push  (out_push),
		.out_data  (out_data)
	);

	gbn_fifo #(
		.WIDTH ($bits(rsp_t)),
		.DEPTH (2)
	) u_rsp_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (out_push),
		.wr_data (out_data),
		.full    (out_full),
		.rd_en   (pop),
		.rd_data (rsp_raw),
		.empty   (empty)
	);

	assign rsp = rsp_t'(rsp_raw);

endmodule

// ===== src/gbn_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module gbn_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic                                     re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== src/gbn_fifo.sv =====
// Small register queue with full and empty flags.
module gbn_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] data_q [DEPTH];
	logic [PW-1:0]    wptr_q;
	logic [PW-1:0]    rptr_q;
	logic [CW-1:0]    count_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = data_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			data_q[wptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + PW'(1);
			end
			if (do_rd) begin
				rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + PW'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CW'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

// ===== src/gbn_cfg.sv =====
// Configuration registers behind the APB-style port.
module gbn_cfg
	import gbn_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t       cfg_q;
	logic       wr;
	logic [1:0] idx;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;
	assign idx    = paddr[3:2];
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.win_len      <= 5'd4;
			cfg_q.frame_total  <= 16'd8;
			cfg_q.impair_frame <= 17'h1FFFF;
			cfg_q.impair_kind  <= 2'd0;
		end else if (wr) begin
			case (idx)
				REG_WIN_LEN:      cfg_q.win_len      <= pwdata[4:0];
				REG_FRAME_TOTAL:  cfg_q.frame_total  <= pwdata[15:0];
				REG_IMPAIR_FRAME: cfg_q.impair_frame <= pwdata[16:0];
				REG_IMPAIR_KIND:  cfg_q.impair_kind  <= pwdata[1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_WIN_LEN:      prdata = DATA_W'(cfg_q.win_len);
			REG_FRAME_TOTAL:  prdata = DATA_W'(cfg_q.frame_total);
			REG_IMPAIR_FRAME: prdata = DATA_W'(cfg_q.impair_frame);
			REG_IMPAIR_KIND:  prdata = DATA_W'(cfg_q.impair_kind);
			default:          prdata = '0;
		endcase
	end

endmodule

// ===== src/gbn_front.sv =====
// Front end: accepts input items, classifies them into commands and queues them.
module gbn_front
	import gbn_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  req_t req,
	output logic full,
	output logic cmd_valid,
	output cmd_t cmd,
	input  logic cmd_pop
);

	cmd_t                   cmd_in;
	logic                   cmd_empty;
	logic [$bits(cmd_t)-1:0] cmd_raw;

	always_comb begin
		cmd_in.ack_seq = req.ack_seq;
		case (req.action)
			ACT_START:   cmd_in.op = CMD_START;
			ACT_ACK:     cmd_in.op = CMD_ACK;
			ACT_TIMEOUT: cmd_in.op = CMD_TIMEOUT;
			default:     cmd_in.op = CMD_NONE;
		endcase
	end

	gbn_fifo #(
		.WIDTH ($bits(cmd_t)),
		.DEPTH (2)
	) u_cmd_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push),
		.wr_data (cmd_in),
		.full    (full),
		.rd_en   (cmd_pop),
		.rd_data (cmd_raw),
		.empty   (cmd_empty)
	);

	assign cmd_valid = !cmd_empty;
	assign cmd       = cmd_t'(cmd_raw);

endmodule

// ===== src/gbn_back.sv =====
// Back end: sequencer that runs commands against the frame ring and emits results.
module gbn_back
	import gbn_pkg::*;
#(
	parameter int MAX_WINDOW = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  logic cmd_valid,
	input  cmd_t cmd,
	output logic cmd_pop,
	input  logic out_full,
	output logic out_push,
	output rsp_t out_data
);

	localparam int SW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int OW = $clog2(MAX_WINDOW + 1);
	localparam int EW = (OW > 5) ? OW : 5;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_EVENT  = 5'b00010,
		ST_FILL   = 5'b00100,
		ST_RESEND = 5'b01000,
		ST_DONE   = 5'b10000
	} state_t;

	state_t        state_q, state_d;
	cmd_t          cmd_q;
	logic [SW-1:0] head_q, head_d;
	logic [OW-1:0] outst_q, outst_d;
	logic [15:0]   next_q, next_d;
	logic [31:0]   tx_q, tx_d;
	logic          active_q, active_d;
	logic [SW-1:0] rslot_q, rslot_d;
	logic [OW-1:0] cnt_q, cnt_d;

	logic          ram_we, ram_re;
	logic [SW-1:0] ram_waddr, ram_raddr;
	ring_entry_t   ram_wdata, ram_rdata;

	logic [EW-1:0] wz, weff;
	logic [4:0]    w5, mask;
	logic [OW:0]   fill_sum;
	logic [SW-1:0] fill_slot;
	logic          fill_ok, fill_more, fill_after;
	logic [4:0]    expect_seq;
	logic [15:0]   att_new;
	logic          hit;

	function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] s);
		return (s == SW'(MAX_WINDOW - 1)) ? '0 : s + SW'(1);
	endfunction

	function automatic rsp_t make_tx(
		input logic [15:0] idx,
		input logic [15:0] att,
		input logic [4:0]  msk,
		input cfg_t        c,
		input logic [31:0] total
	);
		rsp_t       r;
		logic [4:0] seq;
		logic       target;
		target = (att == 16'd1) && !c.impair_frame[16] && (idx == c.impair_frame[15:0]);
		seq    = idx[4:0] & msk;
		r               = '0;
		r.kind          = KIND_TRANSMIT;
		r.frame_index   = idx;
		r.attempt       = att;
		r.ack_loss_mark = target && (c.impair_kind == IMP_ACK_LOSS);
		r.corrupted     = target && (c.impair_kind == IMP_CORRUPT);
		r.wire_seq      = r.corrupted ? ((seq + 5'd1) & msk) : seq;
		r.total_sent    = total;
		return r;
	endfunction

	always_comb begin
		wz   = EW'(cfg.win_len);
		weff = (wz == '0) ? EW'(1) : ((wz > EW'(MAX_WINDOW)) ? EW'(MAX_WINDOW) : wz);
		w5   = weff[4:0];
		mask = w5 | (w5 >> 1) | (w5 >> 2) | (w5 >> 3) | (w5 >> 4);

		fill_sum  = (OW + 1)'(head_q) + (OW + 1)'(outst_q);
		if (fill_sum >= (OW + 1)'(MAX_WINDOW)) begin
			fill_sum = fill_sum - (OW + 1)'(MAX_WINDOW);
		end
		fill_slot = fill_sum[SW-1:0];

		fill_ok    = (EW'(outst_q) < weff) && (next_q < cfg.frame_total);
		fill_more  = (EW'(outst_q) + EW'(1) < weff) &&
			(17'(next_q) + 17'd1 < 17'(cfg.frame_total));
		fill_after = (EW'(outst_q) - EW'(1) < weff) && (next_q < cfg.frame_total);

		expect_seq = ram_rdata.frame[4:0] & mask;
		hit        = (cmd_q.op == CMD_ACK) && (cmd_q.ack_seq == expect_seq);
		att_new    = (ram_rdata.attempts == 16'hFFFF) ? 16'hFFFF
			: ram_rdata.attempts + 16'd1;
	end

	always_comb begin
		state_d   = state_q;
		head_d    = head_q;
		outst_d   = outst_q;
		next_d    = next_q;
		tx_d      = tx_q;
		active_d  = active_q;
		rslot_d   = rslot_q;
		cnt_d     = cnt_q;
		cmd_pop   = 1'b0;
		out_push  = 1'b0;
		out_data  = '0;
		ram_we    = 1'b0;
		ram_waddr = rslot_q;
		ram_wdata = '0;
		ram_re    = 1'b0;
		ram_raddr = head_q;

		case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					cmd_pop = 1'b1;
					case (cmd.op)
						CMD_START: begin
							head_d   = '0;
							outst_d  = '0;
							next_d   = '0;
							tx_d     = '0;
							active_d = 1'b1;
							state_d  = ST_FILL;
						end
						CMD_ACK, CMD_TIMEOUT: begin
							if (active_q && (outst_q != '0)) begin
								ram_re  = 1'b1;
								state_d = ST_EVENT;
							end else begin
								state_d = ST_DONE;
							end
						end
						default: state_d = ST_DONE;
					endcase
				end
			end
			ST_EVENT: begin
				if (!out_full) begin
					out_push             = 1'b1;
					out_data.wire_seq    = expect_seq;
					out_data.frame_index = ram_rdata.frame;
					out_data.attempt     = ram_rdata.attempts;
					out_data.total_sent  = tx_q;
					if (hit) begin
						out_data.kind = KIND_DELIVERED;
						out_data.last = !fill_after && (outst_q != OW'(1));
						head_d        = slot_inc(head_q);
						outst_d       = outst_q - OW'(1);
						state_d       = ST_FILL;
					end else begin
						out_data.kind = (cmd_q.op == CMD_ACK) ? KIND_UNEXPECTED
							: KIND_TIMEOUT;
						ram_re  = 1'b1;
						rslot_d = head_q;
						cnt_d   = '0;
						state_d = ST_RESEND;
					end
				end
			end
			ST_RESEND: begin
				if (!out_full) begin
					out_push           = 1'b1;
					out_data           = make_tx(ram_rdata.frame, att_new, mask, cfg,
						tx_q + 32'd1);
					out_data.last      = (cnt_q == outst_q - OW'(1));
					tx_d               = tx_q + 32'd1;
					ram_we             = 1'b1;
					ram_wdata.frame    = ram_rdata.frame;
					ram_wdata.attempts = att_new;
					if (cnt_q == outst_q - OW'(1)) begin
						state_d = ST_IDLE;
					end else begin
						ram_re    = 1'b1;
						ram_raddr = slot_inc(rslot_q);
						rslot_d   = slot_inc(rslot_q);
						cnt_d     = cnt_q + OW'(1);
					end
				end
			end
			ST_FILL: begin
				if (fill_ok) begin
					if (!out_full) begin
						out_push           = 1'b1;
						out_data           = make_tx(next_q, 16'd1, mask, cfg, tx_q + 32'd1);
						out_data.last      = !fill_more;
						tx_d               = tx_q + 32'd1;
						outst_d            = outst_q + OW'(1);
						next_d             = next_q + 16'd1;
						ram_we             = 1'b1;
						ram_waddr          = fill_slot;
						ram_wdata.frame    = next_q;
						ram_wdata.attempts = 16'd1;
						if (!fill_more) begin
							state_d = ST_IDLE;
						end
					end
				end else if (outst_q == '0) begin
					active_d = 1'b0;
					state_d  = ST_DONE;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_DONE: begin
				if (!out_full) begin
					out_push            = 1'b1;
					out_data.kind       = KIND_IDLE;
					out_data.total_sent = tx_q;
					out_data.last       = 1'b1;
					state_d             = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cmd_q <= cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			head_q   <= '0;
			outst_q  <= '0;
			next_q   <= '0;
			tx_q     <= '0;
			active_q <= 1'b0;
			rslot_q  <= '0;
			cnt_q    <= '0;
		end else begin
			state_q  <= state_d;
			head_q   <= head_d;
			outst_q  <= outst_d;
			next_q   <= next_d;
			tx_q     <= tx_d;
			active_q <= active_d;
			rslot_q  <= rslot_d;
			cnt_q    <= cnt_d;
		end
	end

	gbn_ram #(
		.WIDTH ($bits(ring_entry_t)),
		.DEPTH (MAX_WINDOW)
	) u_ring (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

endmodule
